// ===== rtl/fwf_pkg.sv =====
`timescale 1ns / 1ps

package fwf_pkg;

    typedef enum logic [1:0] {
        REQ_PAT_WRITE = 2'd0,
        REQ_MSG       = 2'd1,
        REQ_CLEAR     = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        RSN_CLEAN   = 2'd0,
        RSN_PATTERN = 2'd1,
        RSN_DIGITS  = 2'd2
    } t_reason;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [1:0] DIGIT_LIMIT = 2'd2;
    localparam logic [1:0] DIGIT_SAT   = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] pattern_index;
        logic [4:0] char_pos;
        logic [7:0] char_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic       forbidden;
        logic [1:0] reason;
    } t_out_word;

endpackage

// ===== rtl/fwf_if.sv =====
`timescale 1ns / 1ps

interface fwf_in_if import fwf_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fwf_out_if import fwf_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fwf_pattern_bank.sv =====
`timescale 1ns / 1ps

module fwf_pattern_bank import fwf_pkg::*; #(
    parameter int NUM_PATTERNS    = 16,
    parameter int MAX_PATTERN_LEN = 32,
    parameter int SW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1,
    parameter int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1,
    parameter int LW = $clog2(MAX_PATTERN_LEN + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [SW-1:0]                     i_wr_slot,
    input  logic [PW-1:0]                     i_wr_pos,
    input  logic [7:0]                        i_wr_byte,
    input  logic                              i_wr_last,
    input  logic [LW-1:0]                     i_wr_len,
    input  logic                              i_rd_en,
    input  logic [SW-1:0]                     i_rd_slot,
    output logic [MAX_PATTERN_LEN-1:0][7:0]   o_align,
    output logic [LW-1:0]                     o_len
);

    logic [MAX_PATTERN_LEN-1:0][7:0] r_mem [NUM_PATTERNS];
    logic [LW-1:0]                   r_len_mem [NUM_PATTERNS];

    logic [MAX_PATTERN_LEN-1:0][7:0] r_row;
    logic [LW-1:0]                   r_len;
    logic [MAX_PATTERN_LEN-1:0][7:0] r_align;
    logic [LW-1:0]                   r_len2;

    logic [MAX_PATTERN_LEN-1:0][7:0] rev;
    logic [MAX_PATTERN_LEN-1:0][7:0] n_align;
    logic [LW-1:0]                   shift_amt;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot][i_wr_pos] <= i_wr_byte;
            if (i_wr_last) begin
                r_len_mem[i_wr_slot] <= i_wr_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_row <= r_mem[i_rd_slot];
            r_len <= r_len_mem[i_rd_slot];
        end
    end

    // aligned[j] = row[len-1-j]: reverse the row, then shift down by MAX-len bytes
    always_comb begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            rev[i] = r_row[MAX_PATTERN_LEN-1-i];
        end
        shift_amt = LW'(MAX_PATTERN_LEN) - r_len;
        n_align   = rev >> {shift_amt, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        r_align <= n_align;
        r_len2  <= r_len;
    end

    assign o_align = r_align;
    assign o_len   = r_len2;

endmodule

// ===== rtl/forbidden_word_filter.sv =====
`timescale 1ns / 1ps

// Forbidden word filter.
// i_in carries request words: pattern byte writes, message bytes and a clear of
// all patterns. o_out carries one verdict word per message, on its last byte.
// i_cfg_we/i_cfg_wdata set filter_enable; write it only while the block is idle.
// A pattern write or clear is taken in the idle state. A non-space message byte
// scans all NUM_PATTERNS pattern rows: one pattern row is read per cycle from the
// pattern memory, then the read/align/compare pipeline drains. A space byte is
// taken in the idle state. After a last byte the finish state loads the verdict
// into the output register.
// The output register holds one verdict; new bytes are taken while it waits,
// and a further verdict waits in the finish state until o_out.ready frees it.
// Reset (synchronous, active low) disables the filter, invalidates all patterns
// and clears the message state; pattern memory contents stay undefined until
// written. No clearing pass is needed.
module forbidden_word_filter import fwf_pkg::*; #(
    parameter int NUM_PATTERNS    = 16,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fwf_in_if.sink     i_in,
    fwf_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    localparam int SW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_PATTERNS - 1);

    t_state                           r_state, n_state;
    logic [SW-1:0]                    r_scan_addr;
    logic                             r_s1_act, r_s1_hit, r_s2_act, r_s2_hit;
    logic                             r_last;
    logic [MAX_PATTERN_LEN-1:0][7:0]  r_recent, n_recent;
    logic [LW-1:0]                    r_fill;
    logic [1:0]                       r_digits;
    logic                             r_match;
    logic                             r_enable;
    logic [NUM_PATTERNS-1:0]          r_pat_valid;
    logic                             r_out_valid;
    t_out_word                        r_out_data, n_out_data;

    t_in_word                         dat;
    logic                             in_fire, msg_fire, pat_wr_ok, clr_fire;
    logic                             is_space, is_digit, out_free;
    logic                             rd_en, load_out, cmp_hit;
    logic [MAX_PATTERN_LEN-1:0][7:0]  align;
    logic [LW-1:0]                    pat_len;
    logic [MAX_PATTERN_LEN-1:0]       eq;

    assign dat       = i_in.data;
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire   = i_in.valid && i_in.ready;
    assign msg_fire  = in_fire && (dat.req_type == REQ_MSG);
    assign clr_fire  = in_fire && (dat.req_type == REQ_CLEAR);
    assign pat_wr_ok = in_fire && (dat.req_type == REQ_PAT_WRITE)
                       && (32'(dat.pattern_index) < NUM_PATTERNS)
                       && (32'(dat.char_pos) < MAX_PATTERN_LEN);
    assign is_space  = (dat.char_byte == CH_SPACE);
    assign is_digit  = (dat.char_byte >= CH_ZERO) && (dat.char_byte <= CH_NINE);
    assign out_free  = !r_out_valid || o_out.ready;

    fwf_pattern_bank #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .SW              (SW),
        .PW              (PW),
        .LW              (LW)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (pat_wr_ok),
        .i_wr_slot (SW'(dat.pattern_index)),
        .i_wr_pos  (PW'(dat.char_pos)),
        .i_wr_byte (dat.char_byte),
        .i_wr_last (dat.is_last),
        .i_wr_len  (LW'({1'b0, dat.char_pos}) + LW'(1)),
        .i_rd_en   (rd_en),
        .i_rd_slot (r_scan_addr),
        .o_align   (align),
        .o_len     (pat_len)
    );

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (msg_fire) begin
                    if (!is_space) begin
                        n_state = ST_SCAN;
                    end else if (dat.is_last) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (r_scan_addr == LAST_SLOT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_act && !r_s2_act) begin
                    n_state = r_last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            eq[j] = (LW'(j) >= pat_len) || (align[j] == r_recent[j]);
        end
        cmp_hit = (&eq) && (pat_len != '0) && (pat_len <= r_fill);
    end

    always_comb begin
        n_recent[0] = dat.char_byte;
        for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
            n_recent[j] = r_recent[j-1];
        end
    end

    always_comb begin
        n_out_data.forbidden = 1'b0;
        n_out_data.reason    = RSN_CLEAN;
        if (r_enable) begin
            if (r_match) begin
                n_out_data.forbidden = 1'b1;
                n_out_data.reason    = RSN_PATTERN;
            end else if (r_digits > DIGIT_LIMIT) begin
                n_out_data.forbidden = 1'b1;
                n_out_data.reason    = RSN_DIGITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_s1_act    <= 1'b0;
            r_s1_hit    <= 1'b0;
            r_s2_act    <= 1'b0;
            r_s2_hit    <= 1'b0;
            r_fill      <= '0;
            r_digits    <= '0;
            r_match     <= 1'b0;
            r_last      <= 1'b0;
            r_enable    <= 1'b0;
            r_pat_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_scan_addr <= (r_scan_addr == LAST_SLOT) ? '0 : r_scan_addr + SW'(1);
            end
            r_s1_act <= rd_en;
            r_s1_hit <= rd_en && r_pat_valid[r_scan_addr];
            r_s2_act <= r_s1_act;
            r_s2_hit <= r_s1_hit;

            if (msg_fire) begin
                r_last <= dat.is_last;
            end

            if (load_out) begin
                r_fill   <= '0;
                r_digits <= '0;
                r_match  <= 1'b0;
            end else begin
                if (msg_fire && !is_space) begin
                    if (r_fill != LW'(MAX_PATTERN_LEN)) begin
                        r_fill <= r_fill + LW'(1);
                    end
                    if (is_digit && (r_digits != DIGIT_SAT)) begin
                        r_digits <= r_digits + 2'd1;
                    end
                end
                if (r_s2_hit && cmp_hit) begin
                    r_match <= 1'b1;
                end
            end

            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end

            if (clr_fire) begin
                r_pat_valid <= '0;
            end else if (pat_wr_ok) begin
                r_pat_valid[SW'(dat.pattern_index)] <= dat.is_last;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (msg_fire && !is_space) begin
            r_recent <= n_recent;
        end
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
